### design/pressure_sensor_cubic_with_rate_unit_assert.svh
// Assertion macros for the checker module.
`ifndef PRESSURE_SENSOR_CUBIC_WITH_RATE_UNIT_ASSERT_SVH
`define PRESSURE_SENSOR_CUBIC_WITH_RATE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/psc_pkg.sv
package psc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 16;
  localparam int W           = 32;
  // Horner accumulator: |acc| stays below 2^33, two guard bits on top.
  localparam int ACC_W       = 36;
  // Multiplier B port: 16-bit unsigned operands, zero extended.
  localparam int MUL_B_W     = 17;
  localparam int MUL_P_W     = ACC_W + MUL_B_W;
  localparam int CFG_IDX_W   = 3;

  localparam logic signed [W-1:0] RATE_MAX = 32'sd2147483647;
  localparam logic signed [W-1:0] RATE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic [W-1:0]           now_tick;
  } psc_in_t;

  typedef struct packed {
    logic signed [W-1:0] pressure_kpa;
    logic signed [W-1:0] pressure_rate;
    logic                rate_updated;
  } psc_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_C0  = 3'd0,
    CFG_COEF_C1  = 3'd1,
    CFG_COEF_C2  = 3'd2,
    CFG_COEF_C3  = 3'd3,
    CFG_TPS      = 3'd4,
    CFG_RATE_HZ  = 3'd5
  } psc_cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POLY_MUL,
    ST_POLY_ADD,
    ST_CHK_MUL,
    ST_CHK,
    ST_RMUL_LO,
    ST_RMUL_HI,
    ST_RACC,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } psc_state_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } psc_div_stat_t;

endpackage

### design/psc_mul.sv
module psc_mul (
  input  logic                                clk,
  input  logic signed [psc_pkg::ACC_W-1:0]    a,
  input  logic signed [psc_pkg::MUL_B_W-1:0]  b,
  output logic signed [psc_pkg::MUL_P_W-1:0]  p_r
);
  import psc_pkg::*;

  // single signed multiplier, result registered
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

### design/psc_div.sv
module psc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [2*psc_pkg::W-1:0]         dividend,
  input  logic [psc_pkg::W-1:0]           divisor,
  output psc_pkg::psc_div_stat_t          stat,
  output logic [psc_pkg::W-1:0]           quo
);
  import psc_pkg::*;

  localparam int CNT_W = $clog2(W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic             ovf_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient of 2^W or more: flagged up front, iterations then don't matter
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[2*W-1:W];
      quo_r <= dividend[W-1:0];
      ovf_r <= (dividend[2*W-1:W] >= divisor);
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[W-1:0] : trial[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quo       = quo_r;

endmodule

### design/pressure_sensor_cubic_with_rate_unit.sv
// Cubic pressure calibration with rate-limited derivative.
// Input channel (in_valid/in_ready/in_data): one converter sample and the
// current free-running tick per transaction. Output channel
// (out_valid/out_ready/out_data): calibrated pressure (Q16.16 kPa,
// saturated), rate in kPa/s (Q16.16, saturated, held between updates) and
// a flag set when this transaction produced a new rate.
// One 36x17 multiplier is reused for the three Horner steps, the interval
// test and two partial products of the rate; a bit-serial divider forms the
// rate quotient. in_ready is high only when the sequencer is idle.
// When the rate is updated, the result follows the Horner steps, the interval
// test, the rate partial products and the divider; when it is not, the rate
// steps are skipped. A new item is accepted only once the sequencer is idle.
// The result sits in an output register: a stalled receiver does not stop
// the next transaction being accepted, but the sequencer waits in its last
// state until that register is free.
// Reset (synchronous, rst_n low) restores the default coefficients and
// clears last update tick, last update pressure and held rate. No clearing
// pass is needed. Configuration writes take effect at once.
module pressure_sensor_cubic_with_rate_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  psc_pkg::psc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output psc_pkg::psc_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [psc_pkg::W-1:0]             cfg_wdata
);
  import psc_pkg::*;

  localparam logic signed [MUL_P_W-1:0] RND_HALF = MUL_P_W'(1) << (SAMPLE_BITS - 1);
  localparam logic signed [W-1:0]       C1_RST   = W'(1) << FRAC_BITS;
  localparam logic [W-1:0]              TPS_RST  = 32'd1000000;
  localparam logic [15:0]               HZ_RST   = 16'd100;

  function automatic logic signed [W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(RATE_MAX);
    lo = ACC_W'(RATE_MIN);
    if (v > hi) return RATE_MAX;
    if (v < lo) return RATE_MIN;
    return v[W-1:0];
  endfunction

  // configuration registers
  logic signed [W-1:0] c0_r, c1_r, c2_r, c3_r;
  logic [W-1:0]        tps_r;
  logic [15:0]         hz_r;

  // sequencer and datapath
  psc_state_t               state_r, state_nxt;
  logic [1:0]               step_r;
  logic [SAMPLE_BITS-1:0]   smp_r;
  logic [W-1:0]             now_r;
  logic [W-1:0]             elapsed_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [W-1:0]      press_r;
  logic                     neg_r;
  logic [W-1:0]             mag_r;
  logic [2*W-1:0]           prod_r;
  logic                     upd_r;

  // architectural state
  logic [W-1:0]             last_tick_r;
  logic signed [W-1:0]      last_press_r;
  logic signed [W-1:0]      held_rate_r;

  // output register
  logic                     out_valid_r;
  psc_out_t                 out_data_r;

  // shared units
  logic signed [ACC_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      div_start;
  psc_div_stat_t             div_stat;
  logic [W-1:0]              div_quo;

  // combinational helpers
  logic                      in_acc;
  logic                      out_free;
  logic [15:0]               hz_eff;
  logic signed [MUL_P_W-1:0] rnd_sum;
  logic signed [MUL_P_W-1:0] rnd_sh;
  logic signed [W-1:0]       coef_sel;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic                      upd_now;
  logic signed [W:0]         dp;
  logic signed [W:0]         dp_abs;
  logic signed [W-1:0]       rate_new;

  psc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  psc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (elapsed_r),
    .stat     (div_stat),
    .quo      (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r  <= '0;
      c1_r  <= C1_RST;
      c2_r  <= '0;
      c3_r  <= '0;
      tps_r <= TPS_RST;
      hz_r  <= HZ_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_COEF_C0: c0_r  <= cfg_wdata;
        CFG_COEF_C1: c1_r  <= cfg_wdata;
        CFG_COEF_C2: c2_r  <= cfg_wdata;
        CFG_COEF_C3: c3_r  <= cfg_wdata;
        CFG_TPS:     tps_r <= cfg_wdata;
        CFG_RATE_HZ: hz_r  <= cfg_wdata[15:0];
        default: ;   // unmapped index, write dropped
      endcase
    end
  end

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign hz_eff   = (hz_r == '0) ? 16'd1 : hz_r;

  // Horner step: acc = c_k + round(acc * s / 2^SAMPLE_BITS), ties upward
  always_comb begin
    rnd_sum = mul_p + RND_HALF;
    rnd_sh  = rnd_sum >>> SAMPLE_BITS;
    case (step_r)
      2'd0:    coef_sel = c2_r;
      2'd1:    coef_sel = c1_r;
      default: coef_sel = c0_r;
    endcase
    acc_nxt = ACC_W'(coef_sel) + rnd_sh[ACC_W-1:0];
  end

  // elapsed >= floor(tps / hz)  <=>  (elapsed + 1) * hz > tps
  assign upd_now = (elapsed_r != '0) &&
                   (mul_p > $signed({{(MUL_P_W-W){1'b0}}, tps_r}));

  always_comb begin
    dp     = {press_r[W-1], press_r} - {last_press_r[W-1], last_press_r};
    dp_abs = dp[W] ? -dp : dp;
  end

  // truncated quotient, saturated with sign
  always_comb begin
    if (neg_r) begin
      if (div_stat.ovf || (div_quo > W'(RATE_MIN))) rate_new = RATE_MIN;
      else                                          rate_new = -$signed(div_quo);
    end else begin
      if (div_stat.ovf || div_quo[W-1]) rate_new = RATE_MAX;
      else                              rate_new = $signed(div_quo);
    end
  end

  // sequencer: next state, handshake and shared-unit operands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_a     = acc_r;
    mul_b     = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = ST_POLY_MUL;
      end
      ST_POLY_MUL: begin
        mul_b     = {{(MUL_B_W-SAMPLE_BITS){1'b0}}, smp_r};
        state_nxt = ST_POLY_ADD;
      end
      ST_POLY_ADD: begin
        state_nxt = (step_r == 2'd2) ? ST_CHK_MUL : ST_POLY_MUL;
      end
      ST_CHK_MUL: begin
        mul_a     = $signed({{(ACC_W-W){1'b0}}, elapsed_r}) + ACC_W'(1);
        mul_b     = {1'b0, hz_eff};
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        state_nxt = upd_now ? ST_RMUL_LO : ST_DONE;
      end
      ST_RMUL_LO: begin
        mul_a     = $signed({{(ACC_W-W){1'b0}}, mag_r});
        mul_b     = {1'b0, tps_r[15:0]};
        state_nxt = ST_RMUL_HI;
      end
      ST_RMUL_HI: begin
        mul_a     = $signed({{(ACC_W-W){1'b0}}, mag_r});
        mul_b     = {1'b0, tps_r[W-1:16]};
        state_nxt = ST_RACC;
      end
      ST_RACC: begin
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          smp_r     <= in_data.adc_sample;
          now_r     <= in_data.now_tick;
          elapsed_r <= in_data.now_tick - last_tick_r;   // wraps mod 2^32
          acc_r     <= ACC_W'(c3_r);
          step_r    <= 2'd0;
        end
      end
      ST_POLY_ADD: begin
        acc_r  <= acc_nxt;
        step_r <= step_r + 2'd1;
      end
      ST_CHK_MUL: begin
        press_r <= sat32(acc_r);
      end
      ST_CHK: begin
        upd_r <= upd_now;
        neg_r <= dp[W];
        mag_r <= dp_abs[W-1:0];
      end
      ST_RMUL_HI: begin
        prod_r <= {{(2*W-48){1'b0}}, mul_p[47:0]};        // mag * tps[15:0]
      end
      ST_RACC: begin
        prod_r <= prod_r + {mul_p[47:0], 16'b0};          // + mag * tps[31:16] << 16
      end
      default: ;
    endcase
  end

  // last-update state and held rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tick_r  <= '0;
      last_press_r <= '0;
      held_rate_r  <= '0;
    end else if (state_r == ST_DIV_WAIT && div_stat.done) begin
      last_tick_r  <= now_r;
      last_press_r <= press_r;
      held_rate_r  <= rate_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_data_r.pressure_kpa  <= press_r;
      out_data_r.pressure_rate <= held_rate_r;
      out_data_r.rate_updated  <= upd_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/pressure_sensor_cubic_with_rate_unit_chk.sv
`include "pressure_sensor_cubic_with_rate_unit_assert.svh"

module pressure_sensor_cubic_with_rate_unit_chk (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  psc_pkg::psc_out_t    out_data
);
  import psc_pkg::*;

  // one transaction at a time: busy straight after an accept
  `PSC_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // idle sequencer stays ready until a transaction arrives
  `PSC_ASSERT_NXT(a_idle_holds, in_ready && !in_valid, in_ready, "ready dropped while idle")

  // no result can appear the cycle after an accept
  `PSC_ASSERT_NXT(a_no_instant_result, in_valid && in_ready, !out_valid || $stable(out_data), "result too early")

  // stalled result is held
  `PSC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed under stall")

endmodule

bind pressure_sensor_cubic_with_rate_unit pressure_sensor_cubic_with_rate_unit_chk u_chk (.*);
